[design/lssi_pkg.sv]
// shared types and constants for the segment / sphere intersection block
package lssi_pkg;

  localparam int COORD_W    = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] src_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } seg_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } seg_out_t;

endpackage

[design/line_segment_sphere_intersect.sv]
// segment / sphere intersection, fully pipelined, fixed point
//
// input channel (in_valid / in_stall / in_data): one segment per transaction,
// start point and start-to-end vector in signed fixed point.
// result channel (out_valid / out_stall / out_data): one transaction per
// segment, in order: hit flag and first hit point, point zero on a miss.
// config channel (cfg_valid / cfg_ready / cfg_addr / cfg_data): sphere
// centre x, y, z and radius; always ready, change it only while idle.
// the pipeline depth is set by the two square root pipelines (one root bit
// per stage) and the normalizing divider (one quotient bit per stage).
// throughput is one segment per cycle while no result is stalled.
// a stalled result freezes the whole pipeline: in_stall follows out_stall
// while a result is held in the output register.
// reset empties the pipeline, centre goes to 0, radius to 1.0.
module line_segment_sphere_intersect
  import lssi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  seg_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output seg_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_data
);

  localparam int CW  = COORD_W;
  localparam int WW  = CW + 1;                 // src - centre
  localparam int QW  = FRAC_BITS + 1;          // unit vector magnitude
  localparam int L2W = 2 * CW;                 // squared length
  localparam int BW  = CW + 3;                 // b, signed
  localparam int DW  = 2 * CW - 2;             // discriminant, signed
  localparam int SQW = (DW + FRAC_BITS) / 2;   // sqrt of disc << frac
  localparam int RW  = ((BW > SQW) ? BW : SQW) + 2;

  localparam logic [CW-2:0] RADIUS_ONE = {{(CW-2){1'b0}}, 1'b1} << FRAC_BITS;

  typedef struct packed {
    logic [2:0][CW-1:0] src;
    logic [2:0][WW-1:0] w;
    logic [2:0][CW-1:0] dmag;
    logic [2:0]         dneg;
  } front_t;

  typedef struct packed {
    logic [2:0][CW:0]   rem;
    logic [2:0][QW-1:0] q;
    logic [CW-1:0]      den;
    logic [2:0][CW-1:0] src;
    logic [2:0][WW-1:0] w;
    logic [2:0]         dneg;
  } div_t;

  typedef struct packed {
    logic [2:0][CW+1:0] uw;
    logic [2:0][L2W-1:0] ww;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [CW-1:0]      len;
    logic [2:0][CW-1:0] src;
  } prd_t;

  typedef struct packed {
    logic [BW-1:0]      b;
    logic [L2W-1:0]     ww;
    logic [DW-2:0]      rr;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [CW-1:0]      len;
    logic [2:0][CW-1:0] src;
  } sum_t;

  typedef struct packed {
    logic [BW-1:0]      b;
    logic [DW-2:0]      bb;
    logic [L2W-1:0]     ww;
    logic [DW-2:0]      rr;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [CW-1:0]      len;
    logic [2:0][CW-1:0] src;
  } sqr_t;

  typedef struct packed {
    logic [DW-1:0]      disc;
    logic [BW-1:0]      b;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [CW-1:0]      len;
    logic [2:0][CW-1:0] src;
  } dsc_t;

  typedef struct packed {
    logic [BW-1:0]      b;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [CW-1:0]      len;
    logic [2:0][CW-1:0] src;
    logic               dpos;
  } side2_t;

  typedef struct packed {
    logic [CW-1:0]      root;
    logic               ok;
    logic [2:0][QW-1:0] umag;
    logic [2:0]         uneg;
    logic [2:0][CW-1:0] src;
  } rt_t;

  typedef struct packed {
    logic [2:0][CW-1:0] prod;
    logic               ok;
    logic [2:0]         uneg;
    logic [2:0][CW-1:0] src;
  } mul_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [2:0][CW-1:0] center_r;
  logic [CW-2:0]      radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      radius_r <= RADIUS_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_CENTER_X: center_r[0] <= cfg_data;
        REG_CENTER_Y: center_r[1] <= cfg_data;
        REG_CENTER_Z: center_r[2] <= cfg_data;
        REG_RADIUS:   radius_r    <= cfg_data[CW-2:0];
        default:      radius_r    <= radius_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // global advance: everything moves unless a held result is stalled
  // ---------------------------------------------------------------------
  logic en;
  logic out_vld_r;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // stage 1: capture, w = src - centre, |dir|
  // ---------------------------------------------------------------------
  logic               s1_vld_r;
  front_t             s1_r, s1_nxt;
  logic [2:0][CW-1:0] dir;

  always_comb begin
    s1_nxt.src[0] = in_data.src_x;
    s1_nxt.src[1] = in_data.src_y;
    s1_nxt.src[2] = in_data.src_z;
    dir[0]        = in_data.dir_x;
    dir[1]        = in_data.dir_y;
    dir[2]        = in_data.dir_z;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.w[i]    = {s1_nxt.src[i][CW-1], s1_nxt.src[i]} - {center_r[i][CW-1], center_r[i]};
      s1_nxt.dneg[i] = dir[i][CW-1];
      s1_nxt.dmag[i] = dir[i][CW-1] ? (-dir[i]) : dir[i];
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: squares of the segment vector
  // stage 3: squared length
  // ---------------------------------------------------------------------
  logic                s2_vld_r;
  front_t              s2_r;
  logic [2:0][L2W-1:0] s2_sq_r, s2_sq_nxt;
  logic                s3_vld_r;
  front_t              s3_r;
  logic [L2W-1:0]      s3_l2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_sq_nxt[i] = L2W'(s1_r.dmag[i]) * L2W'(s1_r.dmag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= s1_nxt;
      s2_r    <= s1_r;
      s2_sq_r <= s2_sq_nxt;
      s3_r    <= s2_r;
      s3_l2_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // ---------------------------------------------------------------------
  // segment length L = floor(sqrt(dir.dir))
  // ---------------------------------------------------------------------
  logic          sq1_vld;
  logic [CW-1:0] sq1_len;
  front_t        sq1_side;

  lssi_sqrt_pipe #(
    .ROOT_W (CW),
    .SIDE_W ($bits(front_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_op     (s3_l2_r),
    .in_side   (s3_r),
    .out_valid (sq1_vld),
    .out_root  (sq1_len),
    .out_side  (sq1_side)
  );

  // ---------------------------------------------------------------------
  // normalize: |u_i| = floor(|dir_i| << frac / L), three restoring lanes
  // ---------------------------------------------------------------------
  logic div_vld_r [QW];
  div_t div_r     [QW];
  div_t div_in;
  div_t dlast;

  always_comb begin
    div_in.den  = sq1_len;
    div_in.src  = sq1_side.src;
    div_in.w    = sq1_side.w;
    div_in.dneg = sq1_side.dneg;
    div_in.q    = '0;
    for (int i = 0; i < 3; i++) begin
      div_in.rem[i] = {1'b0, sq1_side.dmag[i]};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic  prv_vld;
    div_t  prv;
    div_t  nxt;

    if (k == 0) begin : g_first
      assign prv_vld = sq1_vld;
      assign prv     = div_in;
    end else begin : g_next
      assign prv_vld = div_vld_r[k-1];
      assign prv     = div_r[k-1];
    end

    always_comb begin
      logic         ge;
      logic [CW:0]  rdif;
      nxt = prv;
      for (int i = 0; i < 3; i++) begin
        ge         = (prv.rem[i] >= {1'b0, prv.den});
        rdif       = ge ? (prv.rem[i] - {1'b0, prv.den}) : prv.rem[i];
        nxt.rem[i] = {rdif[CW-1:0], 1'b0};
        nxt.q[i]   = {prv.q[i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[k] <= 1'b0;
      end else if (en) begin
        div_vld_r[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k] <= nxt;
      end
    end
  end

  assign dlast = div_r[QW-1];

  // ---------------------------------------------------------------------
  // products u.w terms and w.w terms, truncated toward zero
  // ---------------------------------------------------------------------
  logic p_vld_r;
  prd_t p_r, p_nxt;

  always_comb begin
    logic [QW-1:0]      umag;
    logic               wneg;
    logic [WW-1:0]      wmag;
    logic [QW+WW-1:0]   uwp;
    logic [CW+1:0]      uwm;
    logic [2*WW-1:0]    wwp;
    p_nxt.len  = dlast.den;
    p_nxt.src  = dlast.src;
    p_nxt.uneg = dlast.dneg;
    for (int i = 0; i < 3; i++) begin
      // zero-length segment gives a zero unit vector
      umag          = (dlast.den == '0) ? '0 : dlast.q[i];
      wneg          = dlast.w[i][WW-1];
      wmag          = wneg ? (-dlast.w[i]) : dlast.w[i];
      uwp           = (QW+WW)'(umag) * (QW+WW)'(wmag);
      uwm           = uwp[QW+WW-1:FRAC_BITS];
      p_nxt.uw[i]   = (dlast.dneg[i] ^ wneg) ? (-uwm) : uwm;
      wwp           = (2*WW)'(wmag) * (2*WW)'(wmag);
      p_nxt.ww[i]   = L2W'(wwp >> FRAC_BITS);
      p_nxt.umag[i] = umag;
    end
  end

  // ---------------------------------------------------------------------
  // sums: b = u.w, ww = w.w, rr = radius^2
  // ---------------------------------------------------------------------
  logic                s_vld_r;
  sum_t                s_r, s_nxt;
  logic [2*CW-3:0]     rrp;

  always_comb begin
    s_nxt.b = {p_r.uw[0][CW+1], p_r.uw[0]} + {p_r.uw[1][CW+1], p_r.uw[1]}
            + {p_r.uw[2][CW+1], p_r.uw[2]};
    s_nxt.ww   = p_r.ww[0] + p_r.ww[1] + p_r.ww[2];
    rrp        = (2*CW-2)'(radius_r) * (2*CW-2)'(radius_r);
    s_nxt.rr   = (DW-1)'(rrp >> FRAC_BITS);
    s_nxt.umag = p_r.umag;
    s_nxt.uneg = p_r.uneg;
    s_nxt.len  = p_r.len;
    s_nxt.src  = p_r.src;
  end

  // ---------------------------------------------------------------------
  // b squared
  // ---------------------------------------------------------------------
  logic            q_vld_r;
  sqr_t            q_r, q_nxt;
  logic [BW-1:0]   bmag;
  logic [2*BW-1:0] bbp;

  always_comb begin
    bmag       = s_r.b[BW-1] ? (-s_r.b) : s_r.b;
    bbp        = (2*BW)'(bmag) * (2*BW)'(bmag);
    q_nxt.b    = s_r.b;
    q_nxt.bb   = (DW-1)'(bbp >> FRAC_BITS);
    q_nxt.ww   = s_r.ww;
    q_nxt.rr   = s_r.rr;
    q_nxt.umag = s_r.umag;
    q_nxt.uneg = s_r.uneg;
    q_nxt.len  = s_r.len;
    q_nxt.src  = s_r.src;
  end

  // ---------------------------------------------------------------------
  // discriminant b*b - w.w + r*r
  // ---------------------------------------------------------------------
  logic d_vld_r;
  dsc_t d_r, d_nxt;

  always_comb begin
    d_nxt.disc = DW'(q_r.bb) - DW'(q_r.ww) + DW'(q_r.rr);
    d_nxt.b    = q_r.b;
    d_nxt.umag = q_r.umag;
    d_nxt.uneg = q_r.uneg;
    d_nxt.len  = q_r.len;
    d_nxt.src  = q_r.src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= div_vld_r[QW-1];
      s_vld_r <= p_vld_r;
      q_vld_r <= s_vld_r;
      d_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      s_r <= s_nxt;
      q_r <= q_nxt;
      d_r <= d_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // sqrt of the discriminant, with frac bits kept; a miss feeds zero
  // ---------------------------------------------------------------------
  logic             dpos;
  logic [2*SQW-1:0] sq2_op;
  side2_t           side2_in;
  logic             sq2_vld;
  logic [SQW-1:0]   sq2_root;
  side2_t           sq2_side;

  always_comb begin
    dpos          = !d_r.disc[DW-1];
    sq2_op        = dpos ? (2*SQW)'({d_r.disc[DW-2:0], {FRAC_BITS{1'b0}}}) : '0;
    side2_in.b    = d_r.b;
    side2_in.umag = d_r.umag;
    side2_in.uneg = d_r.uneg;
    side2_in.len  = d_r.len;
    side2_in.src  = d_r.src;
    side2_in.dpos = dpos;
  end

  lssi_sqrt_pipe #(
    .ROOT_W (SQW),
    .SIDE_W ($bits(side2_t))
  ) u_disc_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_vld_r),
    .in_op     (sq2_op),
    .in_side   (side2_in),
    .out_valid (sq2_vld),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  // ---------------------------------------------------------------------
  // roots: near root first, then far root, each tested against 0..L
  // ---------------------------------------------------------------------
  logic    r_vld_r;
  rt_t     r_r, r_nxt;

  always_comb begin
    logic [RW-1:0] nb;
    logic [RW-1:0] sqx;
    logic [RW-1:0] r1;
    logic [RW-1:0] r2;
    logic          ok1;
    logic          ok2;
    nb  = -({{(RW-BW){sq2_side.b[BW-1]}}, sq2_side.b});
    sqx = RW'(sq2_root);
    r1  = nb - sqx;
    r2  = nb + sqx;
    ok1 = sq2_side.dpos && !r1[RW-1] && (r1 <= RW'(sq2_side.len));
    ok2 = sq2_side.dpos && !r2[RW-1] && (r2 <= RW'(sq2_side.len));
    r_nxt.root = ok1 ? r1[CW-1:0] : r2[CW-1:0];
    r_nxt.ok   = ok1 || ok2;
    r_nxt.umag = sq2_side.umag;
    r_nxt.uneg = sq2_side.uneg;
    r_nxt.src  = sq2_side.src;
  end

  // ---------------------------------------------------------------------
  // root * u
  // ---------------------------------------------------------------------
  logic m_vld_r;
  mul_t m_r, m_nxt;

  always_comb begin
    logic [CW+QW-1:0] prodp;
    m_nxt.ok   = r_r.ok;
    m_nxt.uneg = r_r.uneg;
    m_nxt.src  = r_r.src;
    for (int i = 0; i < 3; i++) begin
      prodp         = (CW+QW)'(r_r.root) * (CW+QW)'(r_r.umag[i]);
      m_nxt.prod[i] = CW'(prodp >> FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------
  // output register: src + root*u, clamped to the coordinate range
  // ---------------------------------------------------------------------
  seg_out_t           out_r, out_nxt;
  logic [2:0][CW-1:0] coord;

  always_comb begin
    logic [CW+1:0] pm;
    logic [CW+1:0] sum;
    for (int i = 0; i < 3; i++) begin
      pm  = {2'b00, m_r.prod[i]};
      sum = {{2{m_r.src[i][CW-1]}}, m_r.src[i]} + (m_r.uneg[i] ? (-pm) : pm);
      if (sum[CW+1:CW-1] == 3'b000 || sum[CW+1:CW-1] == 3'b111) begin
        coord[i] = sum[CW-1:0];
      end else if (sum[CW+1]) begin
        coord[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        coord[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    out_nxt.hit   = m_r.ok;
    out_nxt.hit_x = m_r.ok ? coord[0] : '0;
    out_nxt.hit_y = m_r.ok ? coord[1] : '0;
    out_nxt.hit_z = m_r.ok ? coord[2] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      r_vld_r   <= sq2_vld;
      m_vld_r   <= r_vld_r;
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_nxt;
      m_r   <= m_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // pipeline is empty right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a miss carries a zero point
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.hit_z == '0)
    else $error("miss with nonzero point");

  // x component of the unit vector never exceeds 1.0
  assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[QW-1] && dlast.den != '0 |->
      !(dlast.q[0][FRAC_BITS] && (|dlast.q[0][FRAC_BITS-1:0])))
    else $error("normalized component above one");

endmodule

[design/lssi_sqrt_pipe.sv]
// pipelined integer square root, one result bit per stage
module lssi_sqrt_pipe #(
  parameter int ROOT_W = 32,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_op,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int OP_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [OP_W-1:0]   op_r   [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              prv_vld;
    logic [REM_W-1:0]  prv_rem;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] prv_root;
    logic [ROOT_W-1:0] root_nxt;
    logic [OP_W-1:0]   prv_op;
    logic [SIDE_W-1:0] prv_side;
    logic              ge;

    if (k == 0) begin : g_first
      assign prv_vld  = in_valid;
      assign prv_rem  = '0;
      assign prv_root = '0;
      assign prv_op   = in_op;
      assign prv_side = in_side;
    end else begin : g_next
      assign prv_vld  = vld_r[k-1];
      assign prv_rem  = rem_r[k-1];
      assign prv_root = root_r[k-1];
      assign prv_op   = op_r[k-1];
      assign prv_side = side_r[k-1];
    end

    // bring down two operand bits, try root*4+1
    always_comb begin
      rem_sh   = {prv_rem[REM_W-3:0], prv_op[OP_W-1 -: 2]};
      trial    = {prv_root, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {prv_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        op_r[k]   <= prv_op << 2;
        side_r[k] <= prv_side;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule
